// File: design/fctc_pkg.sv
// shared types, codes and constants of the finite-context text classifier
// no dependencies; imported by every design file
package fctc_pkg;

  // default parameter values
  localparam int ORDER_DEF      = 1;
  localparam int COUNT_BITS_DEF = 16;

  // fixed widths
  localparam int INFO_W     = 40;
  localparam int LOG_W      = 22;
  localparam int CNT_ADDR_W = 17;
  localparam int TOT_ADDR_W = 9;
  localparam int AN_W       = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // operation codes
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_SCORE   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // verdict codes
  localparam logic [1:0] VERDICT_B_LOWER = 2'd0;
  localparam logic [1:0] VERDICT_A_LOWER = 2'd1;
  localparam logic [1:0] VERDICT_EQUAL   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET = 2'd1;

  // reset values of the configuration registers
  localparam logic [15:0] ALPHA_RESET    = 16'd256;
  localparam logic [8:0]  ALPHABET_RESET = 9'd256;

  // skipped bytes
  localparam logic [7:0] SYM_TAB     = 8'd9;
  localparam logic [7:0] SYM_NEWLINE = 8'd10;

  typedef struct packed {
    logic [1:0]  operation;
    logic        model_select;
    logic [7:0]  context_index;
    logic [7:0]  symbol;
    logic [15:0] count_value;
  } in_item_t;

  typedef struct packed {
    logic [INFO_W-1:0] model_a_info;
    logic [INFO_W-1:0] model_b_info;
    logic [1:0]        verdict;
    logic              scored;
    logic              skipped;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_LD_WR,
    S_SC_START,
    S_SC_WAIT,
    S_SC_ACC,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic simple;
    logic mem_write;
    logic log_start;
    logic acc_update;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       skip_sym;
    logic       win_full;
    logic       log_done;
    logic       clear_last;
  } stat_t;

endpackage

// File: design/fctc_log2.sv
// fixed-point log2 unit: normalize one stage per cycle, then 16 squaring rounds
// depends on fctc_pkg
module fctc_log2 #(
  parameter int XW = 34
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [XW-1:0]             x,
  output logic                      done,
  output logic [fctc_pkg::LOG_W-1:0] result
);
  import fctc_pkg::*;

  logic [63:0] xs;
  logic [5:0]  top;
  logic [31:0] m;
  logic [15:0] frac;
  logic [4:0]  step;
  logic        busy;
  logic        sq;

  logic [5:0]  shamt;
  logic        hi_zero;
  logic [63:0] xs_next;
  logic [5:0]  top_next;
  logic [31:0] src;
  logic [63:0] prod;

  // binary-search normalization stage
  always_comb begin
    case (step[2:0])
      3'd0: shamt = 6'd32;
      3'd1: shamt = 6'd16;
      3'd2: shamt = 6'd8;
      3'd3: shamt = 6'd4;
      3'd4: shamt = 6'd2;
      3'd5: shamt = 6'd1;
      default: shamt = 6'd0;
    endcase
    hi_zero  = (xs >> (7'd64 - {1'b0, shamt})) == 64'd0;
    xs_next  = hi_zero ? (xs << shamt) : xs;
    top_next = hi_zero ? (top - shamt) : top;
  end

  // squaring round, mantissa has its top bit at bit 31
  always_comb begin
    src  = (step == 5'd0) ? xs[63:32] : m;
    prod = {32'd0, src} * {32'd0, src};
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      xs   <= 64'(x);
      top  <= 6'd63;
      step <= 5'd0;
      sq   <= 1'b0;
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (!sq) begin
        xs  <= xs_next;
        top <= top_next;
        if (step == 5'd5) begin
          sq   <= 1'b1;
          step <= 5'd0;
        end else begin
          step <= step + 5'd1;
        end
      end else begin
        m    <= prod[63] ? prod[63:32] : prod[62:31];
        frac <= {frac[14:0], prod[63]};
        if (step == 5'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 5'd1;
        end
      end
    end
  end

  assign result = {top, frac};

endmodule

// File: design/fctc_ctrl.sv
// controller state machine: clearing pass, item sequencing, output register valid
// depends on fctc_pkg
module fctc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  fctc_pkg::stat_t stat,
  output fctc_pkg::cmd_t  cmd
);
  import fctc_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (stat.clear_last) state_next = S_IDLE;
      S_IDLE: if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        case (stat.op)
          OP_LOAD: state_next = S_LD_WR;
          OP_SCORE: begin
            if (!stat.skip_sym && stat.win_full) state_next = S_SC_START;
            else state_next = S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_LD_WR: state_next = S_DONE;
      S_SC_START: state_next = S_SC_WAIT;
      S_SC_WAIT: if (stat.log_done) state_next = S_SC_ACC;
      S_SC_ACC: state_next = S_DONE;
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd            = '0;
    in_ready       = (state == S_IDLE);
    cmd.clear_step = (state == S_CLEAR);
    cmd.capture    = (state == S_IDLE) && in_valid;
    cmd.simple     = (state == S_DECODE);
    cmd.mem_write  = (state == S_LD_WR);
    cmd.log_start  = (state == S_SC_START);
    cmd.acc_update = (state == S_SC_ACC);
    cmd.out_load   = (state == S_DONE) && (!out_valid || out_ready);
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: design/fctc_dp.sv
// datapath: count and total memories, config registers, window, log2 units,
// accumulators and output register; depends on fctc_pkg and fctc_log2
module fctc_dp #(
  parameter int ORDER      = fctc_pkg::ORDER_DEF,
  parameter int COUNT_BITS = fctc_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  fctc_pkg::cmd_t                  cmd,
  output fctc_pkg::stat_t                 stat,
  input  fctc_pkg::in_item_t              in_data,
  output fctc_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [fctc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fctc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fctc_pkg::*;

  localparam int TOT_W = COUNT_BITS + 8;
  localparam int XW    = COUNT_BITS + 18;
  localparam int NCNT  = 1 << CNT_ADDR_W;
  localparam int NTOT  = 1 << TOT_ADDR_W;

  in_item_t              item;
  logic [15:0]           alpha_scaled;
  logic [8:0]            alphabet_size;
  logic [15:0]           a_eff;
  logic [8:0]            n_eff;
  logic [AN_W-1:0]       an_prod;
  logic [7:0]            window;
  logic [1:0]            fill;
  logic [INFO_W-1:0]     acc_a;
  logic [INFO_W-1:0]     acc_b;
  logic                  scored;
  logic                  skipped;
  logic [CNT_ADDR_W-1:0] clr_addr;

  logic [COUNT_BITS-1:0] cnt_mem [NCNT];
  logic [TOT_W-1:0]      tot_mem [NTOT];
  logic [COUNT_BITS-1:0] rd_cnt0, rd_cnt1;
  logic [TOT_W-1:0]      rd_tot0, rd_tot1;

  logic [COUNT_BITS-1:0] cval;
  logic                  is_load;
  logic [CNT_ADDR_W-1:0] cnt_ra0, cnt_ra1, cnt_wa;
  logic [TOT_ADDR_W-1:0] tot_ra0, tot_ra1, tot_wa;
  logic                  mem_we;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic [TOT_W-1:0]      tot_wd;

  logic [XW-1:0]         den_a, den_b, num_a, num_b;
  logic [LOG_W-1:0]      ld_a, ld_b, ln_a, ln_b;
  logic                  done_da, done_db, done_na, done_nb;
  logic [LOG_W-1:0]      inc_a, inc_b;
  logic [INFO_W:0]       sum_a, sum_b;
  logic [1:0]            verdict;

  // config registers and smoothing product
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_scaled  <= ALPHA_RESET;
      alphabet_size <= ALPHABET_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_ALPHA) alpha_scaled <= cfg_data;
      if (cfg_index == REG_ALPHABET) alphabet_size <= cfg_data[8:0];
    end
  end

  assign a_eff = (alpha_scaled == 16'd0) ? 16'd1 : alpha_scaled;
  assign n_eff = (alphabet_size == 9'd0) ? 9'd1 : alphabet_size;

  always_ff @(posedge clk) begin
    an_prod <= {9'd0, a_eff} * {16'd0, n_eff};
  end

  // item register
  always_ff @(posedge clk) begin
    if (cmd.capture) item <= in_data;
  end

  assign cval    = COUNT_BITS'(item.count_value);
  assign is_load = (item.operation == OP_LOAD);

  // memory addresses: port 0 serves load and model a, port 1 model b
  assign cnt_ra0 = is_load ? {item.model_select, item.context_index, item.symbol}
                           : {1'b0, window, item.symbol};
  assign cnt_ra1 = {1'b1, window, item.symbol};
  assign tot_ra0 = is_load ? {item.model_select, item.context_index} : {1'b0, window};
  assign tot_ra1 = {1'b1, window};

  assign mem_we = cmd.clear_step || cmd.mem_write;
  assign cnt_wa = cmd.clear_step ? clr_addr : cnt_ra0;
  assign tot_wa = cmd.clear_step ? clr_addr[TOT_ADDR_W-1:0] : tot_ra0;
  assign cnt_wd = cmd.clear_step ? '0 : cval;
  assign tot_wd = cmd.clear_step ? '0 : (rd_tot0 - TOT_W'(rd_cnt0) + TOT_W'(cval));

  // count memory
  always_ff @(posedge clk) begin
    if (mem_we) cnt_mem[cnt_wa] <= cnt_wd;
    rd_cnt0 <= cnt_mem[cnt_ra0];
    rd_cnt1 <= cnt_mem[cnt_ra1];
  end

  // context total memory
  always_ff @(posedge clk) begin
    if (mem_we) tot_mem[tot_wa] <= tot_wd;
    rd_tot0 <= tot_mem[tot_ra0];
    rd_tot1 <= tot_mem[tot_ra1];
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + CNT_ADDR_W'(1);
    end
  end

  // log2 arguments
  assign den_a = XW'({rd_tot0, 8'd0}) + XW'(an_prod);
  assign den_b = XW'({rd_tot1, 8'd0}) + XW'(an_prod);
  assign num_a = XW'({rd_cnt0, 8'd0}) + XW'(a_eff);
  assign num_b = XW'({rd_cnt1, 8'd0}) + XW'(a_eff);

  fctc_log2 #(.XW(XW)) u_log_da (
    .clk(clk), .rst(rst), .start(cmd.log_start), .x(den_a), .done(done_da), .result(ld_a)
  );
  fctc_log2 #(.XW(XW)) u_log_db (
    .clk(clk), .rst(rst), .start(cmd.log_start), .x(den_b), .done(done_db), .result(ld_b)
  );
  fctc_log2 #(.XW(XW)) u_log_na (
    .clk(clk), .rst(rst), .start(cmd.log_start), .x(num_a), .done(done_na), .result(ln_a)
  );
  fctc_log2 #(.XW(XW)) u_log_nb (
    .clk(clk), .rst(rst), .start(cmd.log_start), .x(num_b), .done(done_nb), .result(ln_b)
  );

  // information per byte, clamped at zero, and saturating sums
  assign inc_a = (ld_a > ln_a) ? (ld_a - ln_a) : '0;
  assign inc_b = (ld_b > ln_b) ? (ld_b - ln_b) : '0;
  assign sum_a = {1'b0, acc_a} + (INFO_W + 1)'(inc_a);
  assign sum_b = {1'b0, acc_b} + (INFO_W + 1)'(inc_b);

  // window, accumulators and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      fill   <= '0;
      acc_a  <= '0;
      acc_b  <= '0;
    end else if (cmd.simple) begin
      if (item.operation == OP_RESTART) begin
        window <= '0;
        fill   <= '0;
        acc_a  <= '0;
        acc_b  <= '0;
      end else if (item.operation == OP_SCORE && !stat.skip_sym && !stat.win_full) begin
        window <= item.symbol;
        fill   <= fill + 2'd1;
      end
    end else if (cmd.acc_update) begin
      window <= item.symbol;
      acc_a  <= sum_a[INFO_W] ? '1 : sum_a[INFO_W-1:0];
      acc_b  <= sum_b[INFO_W] ? '1 : sum_b[INFO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      scored  <= 1'b0;
      skipped <= 1'b0;
    end else if (cmd.simple) begin
      skipped <= (item.operation == OP_SCORE) && stat.skip_sym;
    end else if (cmd.acc_update) begin
      scored <= 1'b1;
    end
  end

  // verdict and output register
  always_comb begin
    if (acc_a < acc_b) verdict = VERDICT_A_LOWER;
    else if (acc_b < acc_a) verdict = VERDICT_B_LOWER;
    else verdict = VERDICT_EQUAL;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.model_a_info <= acc_a;
      out_data.model_b_info <= acc_b;
      out_data.verdict      <= verdict;
      out_data.scored       <= scored;
      out_data.skipped      <= skipped;
    end
  end

  // status
  assign stat.op         = item.operation;
  assign stat.skip_sym   = (item.symbol == SYM_TAB) || (item.symbol == SYM_NEWLINE);
  assign stat.win_full   = (fill >= 2'(ORDER));
  assign stat.log_done   = done_da && done_db && done_na && done_nb;
  assign stat.clear_last = (clr_addr == '1);

endmodule

// File: design/finite_context_model_text_classifier_unit.sv
// channel   handshake              payload
// in        in_valid / in_ready    in_data  (in_item_t)
// out       out_valid / out_ready  out_data (out_item_t)
// cfg       cfg_we                 cfg_index, cfg_data
//
// after reset a clearing pass zeroes the count and total memories, one entry a
// cycle; no item is taken meanwhile, config writes still apply
// a scored byte waits on the 6 normalize and 16 squaring steps of the four log2
// units; a load passes decode, write and done, other items decode and done
// one item is in flight at a time; the result waits in the output register
// and a stalled output holds the next item in its last step
// top level of the finite-context text classifier
// depends on fctc_pkg, fctc_ctrl, fctc_dp
module finite_context_model_text_classifier_unit #(
  parameter int ORDER      = fctc_pkg::ORDER_DEF,
  parameter int COUNT_BITS = fctc_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fctc_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fctc_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [fctc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fctc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fctc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // controller
  fctc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  // datapath
  fctc_dp #(.ORDER(ORDER), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .in_data(in_data),
    .out_data(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // one item at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another in flight");

  // scored and skipped exclude each other
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.scored && out_data.skipped))
    else $error("result both scored and skipped");

  // verdict agrees with the accumulators
  a_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.verdict == VERDICT_A_LOWER) ==
                   (out_data.model_a_info < out_data.model_b_info)))
    else $error("verdict mismatch");

endmodule

// File: verif/testbench.sv
// self-checking testbench for finite_context_model_text_classifier_unit
// depends on fctc_pkg and the top level; a built-in predictor tracks the count tables
`timescale 1ns / 1ps

module testbench;
  import fctc_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int DRAIN_CYCLES   = 60;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  finite_context_model_text_classifier_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  bit [15:0] counts_mem [0:131071];
  bit [23:0] totals_mem [0:511];
  bit [7:0]  recent_byte;
  int        seen_bytes;
  bit [39:0] bits_a, bits_b;
  bit [15:0] alpha_reg;
  bit [8:0]  alphabet_reg;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        errors, items_in, results_out, scored_seen, idle_cycles, send_gap;
  bit        send_burst, recv_burst;

  // clock
  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // fixed-point log2, 16 fraction bits
  function automatic bit [63:0] log2_fx(bit [63:0] x);
    int top;
    bit [63:0] m, frac;
    top = 0;
    frac = 0;
    if (x == 0) return 0;
    while (top < 63 && (x >> (top + 1)) != 0) top++;
    m = (top >= 31) ? (x >> (top - 31)) : (x << (31 - top));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd2 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (64'(top) << 16) | frac;
  endfunction

  function automatic bit [63:0] symbol_cost(bit model, bit [7:0] ctx, bit [7:0] sym);
    bit [63:0] a, n, cnt, tot, ld, ln;
    a = (alpha_reg != 0) ? alpha_reg : 1;
    n = (alphabet_reg != 0) ? alphabet_reg : 1;
    cnt = counts_mem[{model, ctx, sym}];
    tot = totals_mem[{model, ctx}];
    ld = log2_fx(tot * 256 + a * n);
    ln = log2_fx(cnt * 256 + a);
    return (ld > ln) ? ld - ln : 0;
  endfunction

  function automatic bit [39:0] add_sat(bit [39:0] acc, bit [63:0] inc);
    bit [63:0] s;
    s = 64'(acc) + inc;
    return (s > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : s[39:0];
  endfunction

  // update tables and accumulators for one accepted item, return its result
  function automatic out_item_t classify(in_item_t it);
    out_item_t r;
    bit [16:0] idx;
    r = '0;
    idx = {it.model_select, it.context_index, it.symbol};
    if (it.operation == OP_LOAD) begin
      totals_mem[idx[16:8]] = totals_mem[idx[16:8]] - counts_mem[idx] + it.count_value;
      counts_mem[idx] = it.count_value;
    end else if (it.operation == OP_SCORE) begin
      if (it.symbol == SYM_TAB || it.symbol == SYM_NEWLINE) begin
        r.skipped = 1'b1;
      end else begin
        if (seen_bytes >= 1) begin
          bits_a = add_sat(bits_a, symbol_cost(1'b0, recent_byte, it.symbol));
          bits_b = add_sat(bits_b, symbol_cost(1'b1, recent_byte, it.symbol));
          r.scored = 1'b1;
        end else begin
          seen_bytes++;
        end
        recent_byte = it.symbol;
      end
    end else if (it.operation == OP_RESTART) begin
      recent_byte = '0;
      seen_bytes = 0;
      bits_a = '0;
      bits_b = '0;
    end
    r.model_a_info = bits_a;
    r.model_b_info = bits_b;
    if (bits_a < bits_b) r.verdict = VERDICT_A_LOWER;
    else if (bits_b < bits_a) r.verdict = VERDICT_B_LOWER;
    else r.verdict = VERDICT_EQUAL;
    return r;
  endfunction

  function automatic int pick_gap(bit burst);
    int p;
    p = $urandom_range(99);
    if (burst || p < 55) return 0;
    if (p < 88) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(classify(in_data));
        items_in++;
      end
      if (!in_valid || in_ready) begin
        if ($urandom_range(99) < 3) send_burst = !send_burst;
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap(send_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and checker
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_out++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.scored) scored_seen++;
          if (out_data.model_a_info !== exp_r.model_a_info) begin
            $display("%0t: model_a_info expected %h actual %h", $time,
                     exp_r.model_a_info, out_data.model_a_info);
            errors++;
          end
          if (out_data.model_b_info !== exp_r.model_b_info) begin
            $display("%0t: model_b_info expected %h actual %h", $time,
                     exp_r.model_b_info, out_data.model_b_info);
            errors++;
          end
          if (out_data.verdict !== exp_r.verdict) begin
            $display("%0t: verdict expected %0d actual %0d", $time,
                     exp_r.verdict, out_data.verdict);
            errors++;
          end
          if (out_data.scored !== exp_r.scored) begin
            $display("%0t: scored expected %0d actual %0d", $time,
                     exp_r.scored, out_data.scored);
            errors++;
          end
          if (out_data.skipped !== exp_r.skipped) begin
            $display("%0t: skipped expected %0d actual %0d", $time,
                     exp_r.skipped, out_data.skipped);
            errors++;
          end
        end
      end
      if ($urandom_range(99) < 3) recv_burst = !recv_burst;
      out_ready <= recv_burst || (pick_gap(1'b0) == 0);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("** finite_context_model_text_classifier_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t mk(bit [1:0] op, bit model, bit [7:0] ctx,
                                  bit [7:0] sym, bit [15:0] cnt);
    in_item_t it;
    it.operation = op;
    it.model_select = model;
    it.context_index = ctx;
    it.symbol = sym;
    it.count_value = cnt;
    return it;
  endfunction

  // text-like byte: mostly a small alphabet so table entries are hit
  function automatic bit [7:0] text_byte();
    int p;
    p = $urandom_range(99);
    if (p < 75) return 8'h61 + 8'($urandom_range(5));
    if (p < 85) return $urandom_range(1) ? SYM_TAB : SYM_NEWLINE;
    return 8'($urandom_range(255));
  endfunction

  function automatic in_item_t random_item();
    int p;
    p = $urandom_range(99);
    if (p < 30)
      return mk(OP_LOAD, 1'($urandom_range(1)),
                ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : text_byte(),
                text_byte(), ($urandom_range(4) == 0) ? 16'($urandom_range(65535))
                                                     : 16'($urandom_range(40)));
    if (p < 93)
      return mk(OP_SCORE, 1'($urandom_range(1)), 8'($urandom_range(255)), text_byte(),
                16'($urandom_range(65535)));
    if (p < 97)
      return mk(OP_RESTART, 1'($urandom_range(1)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 16'($urandom_range(65535)));
    return mk(2'd3, 1'($urandom_range(1)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 16'($urandom_range(65535)));
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_ALPHA) alpha_reg = value;
    else alphabet_reg = value[8:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // stimulus
  initial begin
    bit [15:0] alpha_set [5];
    bit [15:0] alphabet_set [5];
    alpha_set = '{16'd256, 16'd1, 16'd65535, 16'd0, 16'd0};
    alphabet_set = '{16'd256, 16'd1, 16'hFFFF, 16'd0, 16'd0};
    alpha_set[4] = 16'($urandom_range(65535, 1));
    alphabet_set[4] = 16'($urandom_range(256, 1));
    errors = 0; items_in = 0; results_out = 0; scored_seen = 0;
    send_burst = 0; recv_burst = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    alpha_reg = ALPHA_RESET;
    alphabet_reg = ALPHABET_RESET;
    recent_byte = '0;
    seen_bytes = 0;
    bits_a = '0;
    bits_b = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, reloads, skips, partial window, unused op
    pending_items.push_back(mk(OP_SCORE, 0, 0, 8'h41, 0));
    pending_items.push_back(mk(OP_SCORE, 0, 0, 8'h42, 0));
    pending_items.push_back(mk(OP_LOAD, 0, 8'h41, 8'h42, 16'hFFFF));
    pending_items.push_back(mk(OP_LOAD, 1, 8'h41, 8'h42, 16'd3));
    pending_items.push_back(mk(OP_LOAD, 1, 8'h41, 8'h43, 16'd7));
    pending_items.push_back(mk(OP_LOAD, 0, 8'hFF, 8'hFF, 16'd1));
    pending_items.push_back(mk(OP_LOAD, 1, 8'h41, 8'h42, 16'd10));
    pending_items.push_back(mk(OP_LOAD, 0, 8'h00, 8'h00, 16'd0));
    pending_items.push_back(mk(OP_RESTART, 1, 8'hFF, 8'hFF, 16'hFFFF));
    pending_items.push_back(mk(OP_SCORE, 0, 0, SYM_TAB, 0));
    pending_items.push_back(mk(OP_SCORE, 0, 0, 8'h41, 0));
    pending_items.push_back(mk(OP_SCORE, 0, 0, SYM_NEWLINE, 0));
    pending_items.push_back(mk(OP_SCORE, 0, 0, 8'h42, 0));
    pending_items.push_back(mk(OP_SCORE, 0, 0, 8'hFF, 0));
    pending_items.push_back(mk(OP_SCORE, 0, 0, 8'hFF, 0));
    pending_items.push_back(mk(OP_SCORE, 0, 0, 8'h00, 0));
    pending_items.push_back(mk(2'd3, 1, 8'hFF, 8'hFF, 16'hFFFF));
    pending_items.push_back(mk(OP_LOAD, 1, 8'hFF, 8'hFF, 16'hFFFF));
    pending_items.push_back(mk(OP_SCORE, 0, 0, 8'hFF, 0));

    // one random phase per register setting
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        wait_idle();
        write_reg(REG_ALPHA, alpha_set[ph]);
        write_reg(REG_ALPHABET, alphabet_set[ph]);
      end
      for (int k = 0; k < 160; k++) pending_items.push_back(random_item());
    end
    wait_idle();

    $display("covered %0d items, %0d results (%0d scored) over 5 register settings",
             items_in, results_out, scored_seen);
    if (errors == 0) begin
      $display("** finite_context_model_text_classifier_unit: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** finite_context_model_text_classifier_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/fctc_pkg.sv
design/fctc_log2.sv
design/fctc_ctrl.sv
design/fctc_dp.sv
design/finite_context_model_text_classifier_unit.sv
verif/testbench.sv
